@@ src/iost_pkg.sv @@
// Package for the insertion-ordered set table.
// Holds the request and response transaction types and the mode codes.
// No dependencies.
package iost_pkg;

    // Request modes
    localparam logic [2:0] MODE_APPEND  = 3'd0;
    localparam logic [2:0] MODE_ADD_NEW = 3'd1;
    localparam logic [2:0] MODE_REMOVE  = 3'd2;
    localparam logic [2:0] MODE_MEMBER  = 3'd3;
    localparam logic [2:0] MODE_READ    = 3'd4;

    // Request transaction
    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] value;
        logic [5:0]         index;
    } t_req;

    // Response transaction
    typedef struct packed {
        logic               hit;
        logic               appended;
        logic               full_refused;
        logic signed [31:0] entry_value;
        logic [6:0]         entry_count;
        logic               nonempty;
        logic signed [31:0] oldest_value;
        logic signed [31:0] newest_value;
    } t_rsp;

endpackage

@@ src/iost_ram.sv @@
// Single-port-write, single-port-read entry store for the set table.
// Read data is registered. No package dependency.
module iost_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/insertion_ordered_set_table.sv @@
// Top level of the insertion-ordered set table: sequencer around one entry store.
// Depends on iost_pkg (types, mode codes) and iost_ram (entry store).
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+-----------------------
//  request | i_in_valid  | o_in_stall   | i_in  (iost_pkg::t_req)
//  result  | o_out_valid | i_out_stall  | o_out (iost_pkg::t_rsp)
//
// The store has one read port, so the search and the gap-closing shift
// each walk one entry per cycle through the same compare and read path.
// Reset clears the entry count and the handshake state; the store itself
// is not cleared. A stalled result holds in the output register while
// the next request is accepted and worked on.
module insertion_ordered_set_table #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  iost_pkg::t_req i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output iost_pkg::t_rsp o_out
);

    import iost_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_SCAN   = 10'b0000000010,
        S_APPEND = 10'b0000000100,
        S_SHIFT  = 10'b0000001000,
        S_RF0    = 10'b0000010000,
        S_RF1    = 10'b0000100000,
        S_RF2    = 10'b0001000000,
        S_RDIX   = 10'b0010000000,
        S_RDCAP  = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    // Control registers
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic            r_cmp_vld, n_cmp_vld;
    logic            r_ovalid, n_ovalid;

    // Payload registers
    logic [2:0]            r_mode, n_mode;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [5:0]            r_idx, n_idx;
    logic [AW-1:0]         r_cmp_idx, n_cmp_idx;
    logic [VALUE_BITS-1:0] r_oldest, n_oldest;
    logic [VALUE_BITS-1:0] r_newest, n_newest;
    logic [VALUE_BITS-1:0] r_ev, n_ev;
    logic                  r_hit, n_hit;
    logic                  r_app, n_app;
    logic                  r_ref, n_ref;
    t_rsp                  r_out, n_out;

    // Store interface
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic [AW-1:0]         rd_addr;
    logic [VALUE_BITS-1:0] rd_q;

    // Width helpers
    logic                  accept;
    logic                  full;
    logic [CW-1:0]         cnt_m1;
    logic [63:0]           in64;
    logic [15:0]           idx16;
    logic [15:0]           cnt16;
    logic [63:0]           old64;
    logic [63:0]           new64;
    logic [63:0]           ev64;
    logic                  more;

    iost_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_BITS),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_q)
    );

    // Handshake and width conversion
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    assign full   = (r_count == CW'(CAPACITY));
    assign cnt_m1 = r_count - CW'(1);
    assign in64   = 64'($unsigned(i_in.value));
    assign idx16  = 16'(r_idx);
    assign cnt16  = 16'(r_count);
    assign old64  = 64'(r_oldest);
    assign new64  = 64'(r_newest);
    assign ev64   = 64'(r_ev);
    assign more   = (r_ptr < r_count);

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_cmp_vld = r_cmp_vld;
        n_cmp_idx = r_cmp_idx;
        n_ovalid  = r_ovalid;
        n_mode    = r_mode;
        n_val     = r_val;
        n_idx     = r_idx;
        n_oldest  = r_oldest;
        n_newest  = r_newest;
        n_ev      = r_ev;
        n_hit     = r_hit;
        n_app     = r_app;
        n_ref     = r_ref;
        n_out     = r_out;
        wr_en     = 1'b0;
        wr_addr   = r_count[AW-1:0];
        wr_data   = r_val;
        rd_addr   = '0;

        // Drop the result once taken
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode    = i_in.mode;
                    n_val     = in64[VALUE_BITS-1:0];
                    n_idx     = i_in.index;
                    n_hit     = 1'b0;
                    n_app     = 1'b0;
                    n_ref     = 1'b0;
                    n_ev      = '0;
                    n_ptr     = '0;
                    n_cmp_vld = 1'b0;
                    case (i_in.mode)
                        MODE_APPEND: n_state = S_APPEND;
                        MODE_ADD_NEW: begin
                            n_state = (r_count == '0) ? S_APPEND : S_SCAN;
                        end
                        MODE_REMOVE, MODE_MEMBER: begin
                            n_state = (r_count == '0) ? S_DONE : S_SCAN;
                        end
                        MODE_READ: n_state = S_RDIX;
                        default:   n_state = S_DONE;
                    endcase
                end
            end

            // Append at the tail unless full
            S_APPEND: begin
                if (full) begin
                    n_ref = 1'b1;
                end else begin
                    wr_en    = 1'b1;
                    n_count  = r_count + CW'(1);
                    n_newest = r_val;
                    n_app    = 1'b1;
                    if (r_count == '0) begin
                        n_oldest = r_val;
                    end
                end
                n_state = S_DONE;
            end

            // Walk entries one a cycle, compare the one read last cycle
            S_SCAN: begin
                if (more) begin
                    rd_addr   = r_ptr[AW-1:0];
                    n_ptr     = r_ptr + CW'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_ptr[AW-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                end
                if (r_cmp_vld) begin
                    if (rd_q == r_val) begin
                        n_hit = 1'b1;
                        if (r_mode == MODE_REMOVE) begin
                            n_ptr     = CW'(r_cmp_idx) + CW'(1);
                            n_cmp_vld = 1'b0;
                            n_state   = S_SHIFT;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else if (CW'(r_cmp_idx) == cnt_m1) begin
                        n_state = (r_mode == MODE_ADD_NEW) ? S_APPEND : S_DONE;
                    end
                end
            end

            // Close the gap: move each later entry down by one
            S_SHIFT: begin
                if (more) begin
                    rd_addr   = r_ptr[AW-1:0];
                    n_ptr     = r_ptr + CW'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_ptr[AW-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                end
                if (r_cmp_vld) begin
                    wr_en   = 1'b1;
                    wr_addr = r_cmp_idx - AW'(1);
                    wr_data = rd_q;
                end
                if (!more && !r_cmp_vld) begin
                    n_count = cnt_m1;
                    n_state = (cnt_m1 == '0) ? S_DONE : S_RF0;
                end
            end

            // Refresh oldest and newest after a removal
            S_RF0: begin
                rd_addr = '0;
                n_state = S_RF1;
            end

            S_RF1: begin
                n_oldest = rd_q;
                rd_addr  = cnt_m1[AW-1:0];
                n_state  = S_RF2;
            end

            S_RF2: begin
                n_newest = rd_q;
                n_state  = S_DONE;
            end

            // Read by arrival index
            S_RDIX: begin
                if (idx16 < cnt16) begin
                    rd_addr = idx16[AW-1:0];
                    n_hit   = 1'b1;
                    n_state = S_RDCAP;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_RDCAP: begin
                n_ev    = rd_q;
                n_state = S_DONE;
            end

            // Hand the result to the output register when it is free
            S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid           = 1'b1;
                    n_out.hit          = r_hit;
                    n_out.appended     = r_app;
                    n_out.full_refused = r_ref;
                    n_out.entry_value  = ev64[31:0];
                    n_out.entry_count  = cnt16[6:0];
                    n_out.nonempty     = (r_count != '0);
                    n_out.oldest_value = (r_count != '0) ? old64[31:0] : 32'd0;
                    n_out.newest_value = (r_count != '0) ? new64[31:0] : 32'd0;
                    n_state            = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ptr     <= '0;
            r_cmp_vld <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ptr     <= n_ptr;
            r_cmp_vld <= n_cmp_vld;
            r_ovalid  <= n_ovalid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_val     <= n_val;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_oldest  <= n_oldest;
        r_newest  <= n_newest;
        r_ev      <= n_ev;
        r_hit     <= n_hit;
        r_app     <= n_app;
        r_ref     <= n_ref;
        r_out     <= n_out;
    end

`ifndef NO_ASSERTIONS
    // An accepted request keeps the request side stalled in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request side not stalled after accept");

    // The entry count moves by at most one per cycle and never past capacity
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_count <= CW'(CAPACITY)) &&
        ((r_count == $past(r_count)) || (r_count == $past(r_count) + CW'(1)) ||
         (r_count == $past(r_count) - CW'(1)))))
        else $error("entry count out of step");

    // An appended result leaves the table nonempty and is never also refused
    a_append_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.appended) |-> (o_out.nonempty && !o_out.full_refused))
        else $error("inconsistent append flags");
`endif

endmodule
